// File: rtl/spq_pkg.sv
// Package with the transaction types and codes of the sorted priority queue.
package spq_pkg;

    // Operation codes carried in the input transaction.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Fixed field widths of the transactions.
    localparam int FIELD_VALUE_W = 16;
    localparam int FIELD_COUNT_W = 5;

    // Input transaction.
    typedef struct packed {
        logic                     operation;
        logic [FIELD_VALUE_W-1:0] value;
    } spq_in_t;

    // Result transaction.
    typedef struct packed {
        logic                     ok;
        logic [FIELD_VALUE_W-1:0] front_value;
        logic [FIELD_COUNT_W-1:0] count;
        logic                     is_empty;
    } spq_out_t;

    // Control broadcast to every cell in the chain.
    typedef struct packed {
        logic load;
        logic dequeue;
    } spq_cell_ctrl_t;

endpackage

// File: rtl/spq_cell.sv
// One storage cell of the sorted chain: holds one entry and shifts with its neighbors.
module spq_cell
    import spq_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   clk,
    input  spq_cell_ctrl_t         ctrl,
    input  logic                   occupied,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [VALUE_WIDTH-1:0] right_value,
    input  logic                   left_ins,
    output logic                   ins,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [VALUE_WIDTH-1:0] value_next
);

    logic [VALUE_WIDTH-1:0] value_reg;

    // The new value goes at or ahead of this cell when this cell is free or larger.
    assign ins = !occupied || (value_reg > new_value);

    // Next entry: shift toward the front on dequeue, open a gap on enqueue.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            if (ctrl.dequeue)
            begin
                value_next = right_value;
            end
            else if (ins)
            begin
                value_next = left_ins ? left_value : new_value;
            end
        end
    end

    // Entry storage; payload only, so no reset.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: rtl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: cell chain, occupancy count and result register.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid, in_ready  | in_data  (operation, value)
//  out     | out_valid, out_ready| out_data (ok, front_value, count, is_empty)
//
// One transaction is taken per cycle: every cell compares and shifts in the same
// cycle, and the result lands in the output register on the next edge.
// in_ready is high whenever the output register is empty or being drained, so a
// result that waits on out_ready holds off the next transaction and the queue.
// Reset clears the count and the output valid; entry contents need no reset.
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  spq_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output spq_out_t out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   out_valid_reg;
    spq_out_t               out_reg;
    logic                   in_fire;
    logic                   is_enq;
    logic                   full;
    logic                   empty;
    logic                   op_ok;
    spq_cell_ctrl_t         ctrl;
    logic [VALUE_WIDTH-1:0] new_value;
    logic [VALUE_WIDTH-1:0] values      [DEPTH];
    logic [VALUE_WIDTH-1:0] values_next [DEPTH];
    logic [DEPTH-1:0]       ins;
    logic [FIELD_VALUE_W-1:0] front_field;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_enq   = (in_data.operation == OP_ENQUEUE);
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign op_ok    = is_enq ? !full : !empty;

    assign ctrl.load    = in_fire && op_ok;
    assign ctrl.dequeue = !is_enq;

    // Fit the input value to the stored width and the front entry to the field width.
    generate
        if (VALUE_WIDTH >= FIELD_VALUE_W)
        begin : g_wide
            assign new_value   = VALUE_WIDTH'(in_data.value);
            assign front_field = values_next[0][FIELD_VALUE_W-1:0];
        end
        else
        begin : g_narrow
            assign new_value   = in_data.value[VALUE_WIDTH-1:0];
            assign front_field = FIELD_VALUE_W'(values_next[0]);
        end
    endgenerate

    // Chain of cells, each tied to its neighbors.
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                   occ;
            logic [VALUE_WIDTH-1:0] left_v;
            logic [VALUE_WIDTH-1:0] right_v;
            logic                   left_i;

            assign occ = (CW'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign left_v = new_value;
                assign left_i = 1'b0;
            end
            else
            begin : g_mid
                assign left_v = values[i-1];
                assign left_i = ins[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_v = values[i];
            end
            else
            begin : g_inner
                assign right_v = values[i+1];
            end

            spq_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occ),
                .new_value  (new_value),
                .left_value (left_v),
                .right_value(right_v),
                .left_ins   (left_i),
                .ins        (ins[i]),
                .value      (values[i]),
                .value_next (values_next[i])
            );
        end
    endgenerate

    // Occupancy after this transaction.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.load)
        begin
            count_next = is_enq ? count_reg + CW'(1) : count_reg - CW'(1);
        end
    end

    // Count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, captured with each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_reg.ok          <= op_ok;
            out_reg.front_value <= (count_next == '0) ? '0 : front_field;
            out_reg.count       <= FIELD_COUNT_W'(count_next);
            out_reg.is_empty    <= (count_next == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The count never passes the depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("occupancy above depth");

    // An enqueue into a full queue is refused.
    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_enq && full) |=> (!out_data.ok && count_reg == CW'(DEPTH)))
        else $error("enqueue accepted while full");

    // A dequeue from an empty queue is refused and reports empty.
    a_empty_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !is_enq && empty) |=> (!out_data.ok && out_data.is_empty))
        else $error("dequeue accepted while empty");

    // The count moves only with an accepted transaction.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(count_reg))
        else $error("count changed without a transaction");

endmodule
